FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the region-to-section table generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

FILE: src/rtsg_pkg.sv
// ----------------------------------------------------------------------------
// rtsg_pkg
// Types, constants and the section match function of the table generator.
// ----------------------------------------------------------------------------
package rtsg_pkg;

    localparam int NUM_REGIONS_DEF = 8;
    localparam int WORD_W          = 32;
    localparam int REGION_NUM_W    = 3;
    localparam int ENTRY_W         = 12;
    localparam int SIZE_W          = 5;
    localparam int START_LSB       = 20;
    localparam int SIZE_LSB        = 12;

    localparam logic [SIZE_W-1:0] SIZE_ONE_SECTION_MAX = SIZE_W'(18);
    localparam logic [SIZE_W-1:0] SIZE_SECTION_BASE    = SIZE_W'(19);
    localparam logic [WORD_W-1:0] ATTR_MASK            = 32'h0000_0dff;
    localparam logic [WORD_W-1:0] FIXED_BITS           = 32'h0000_0012;

    typedef enum logic [1:0] {
        KIND_REGION_READ  = 2'd0,
        KIND_REGION_WRITE = 2'd1,
        KIND_TABLE_READ   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [REGION_NUM_W-1:0] region_number;
        logic [ENTRY_W-1:0]      entry_index;
        logic [WORD_W-1:0]       write_data;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
    } rsp_t;

    typedef struct packed {
        logic                    en;
        logic [REGION_NUM_W-1:0] region_number;
        logic [WORD_W-1:0]       data;
    } region_wr_t;

    // True when section 'entry' lies inside the span of region word 'word'.
    function automatic logic section_hit(input logic [WORD_W-1:0] word,
                                         input logic [ENTRY_W-1:0] entry);
        logic [SIZE_W-1:0]  code;
        logic [ENTRY_W-1:0] start;
        logic [ENTRY_W-1:0] diff;
        logic [SIZE_W-1:0]  shift;
        logic               ge;
        code  = word[SIZE_LSB +: SIZE_W];
        start = word[START_LSB +: ENTRY_W];
        diff  = entry - start;
        ge    = (entry >= start);
        shift = code - SIZE_SECTION_BASE;
        if (code <= SIZE_ONE_SECTION_MAX)
        begin
            return ge && (diff == '0);
        end
        // Span of 1 << shift sections: offset must have no bits at or above shift.
        return ge && ((diff >> shift) == '0);
    endfunction

endpackage

FILE: src/rtsg_stream_if.sv
// ----------------------------------------------------------------------------
// rtsg_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface rtsg_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/rtsg_region_file.sv
// ----------------------------------------------------------------------------
// rtsg_region_file
// Region register storage with one write port; all words visible in parallel.
// ----------------------------------------------------------------------------
module rtsg_region_file #(
    parameter int NUM_REGIONS = rtsg_pkg::NUM_REGIONS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rtsg_pkg::region_wr_t          wr,
    output logic [rtsg_pkg::WORD_W-1:0]   words [NUM_REGIONS]
);
    import rtsg_pkg::*;

    logic [WORD_W-1:0] words_reg [NUM_REGIONS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGIONS; r++)
            begin
                words_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r < NUM_REGIONS; r++)
            begin
                // region numbers without a register are dropped
                if (wr.en && (int'(wr.region_number) == r))
                begin
                    words_reg[r] <= wr.data;
                end
            end
        end
    end

    assign words = words_reg;

endmodule

FILE: src/rtsg_result_logic.sv
// ----------------------------------------------------------------------------
// rtsg_result_logic
// Register read mux and section descriptor lookup over all regions.
// ----------------------------------------------------------------------------
module rtsg_result_logic #(
    parameter int NUM_REGIONS = rtsg_pkg::NUM_REGIONS_DEF
) (
    input  rtsg_pkg::req_t                item,
    input  logic [rtsg_pkg::WORD_W-1:0]   words [NUM_REGIONS],
    output rtsg_pkg::rsp_t                result
);
    import rtsg_pkg::*;

    logic [WORD_W-1:0] reg_val;
    logic [WORD_W-1:0] table_val;

    always_comb
    begin
        reg_val   = '0;
        table_val = '0;
        for (int r = 0; r < NUM_REGIONS; r++)
        begin
            if (int'(item.region_number) == r)
            begin
                reg_val = words[r];
            end
            // later regions override earlier ones
            if (section_hit(words[r], item.entry_index))
            begin
                table_val = {item.entry_index, START_LSB'(0)}
                          | (words[r] & ATTR_MASK) | FIXED_BITS;
            end
        end
    end

    always_comb
    begin
        case (item.kind)
            KIND_REGION_READ:  result.read_data = reg_val;
            KIND_TABLE_READ:   result.read_data = table_val;
            default:           result.read_data = '0;
        endcase
    end

endmodule

FILE: src/region_to_section_table_generator.sv
// ----------------------------------------------------------------------------
// region_to_section_table_generator
// Region registers plus a computed 4096-entry table of 1 MB section words.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one bus access per transfer: region read, region write, or a read
//          of one section table word (kind, region_number, entry_index,
//          write_data).
//   rsp  - one read_data transfer per access, in order; 0 for writes and for
//          unused kinds.
//   Pipeline: a request lands in the input register when it transfers; its
//          result then loads the result register as the access leaves the
//          input register; that register drives rsp.valid and rsp.data.
//   Throughput: one access per cycle while rsp.ready holds high; the range
//          compare over all region registers is combinational between stages.
//   Writes take effect as the access leaves the input register, so a read
//          right behind a write sees the new value.
//   Reset: all region registers clear to zero, both stages empty.
//   Stall: while rsp.ready is low the result register holds; the input
//          register still takes one more access, then req.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module region_to_section_table_generator #(
    parameter int NUM_REGIONS = rtsg_pkg::NUM_REGIONS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rtsg_stream_if.sink   req,
    rtsg_stream_if.source rsp
);
    import rtsg_pkg::*;

    // Stage 1: input register
    logic  s1_valid_reg;
    logic  s1_valid_next;
    req_t  s1_item_reg;

    // Stage 2: result register
    logic  out_valid_reg;
    logic  out_valid_next;
    rsp_t  out_item_reg;

    logic  out_adv;     // result register may load
    logic  s1_adv;      // access moves from input to result register
    logic  in_xfer;     // request transfer this cycle

    region_wr_t        wr;
    logic [WORD_W-1:0] words [NUM_REGIONS];
    rsp_t              result;

    assign out_adv   = !out_valid_reg || rsp.ready;
    assign s1_adv    = s1_valid_reg && out_adv;
    assign req.ready = !s1_valid_reg || out_adv;
    assign in_xfer   = req.valid && req.ready;

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !out_adv);
    assign out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;

    // Region write is committed as the access retires from stage 1
    assign wr.en            = s1_adv && (s1_item_reg.kind == KIND_REGION_WRITE);
    assign wr.region_number = s1_item_reg.region_number;
    assign wr.data          = s1_item_reg.write_data;

    rtsg_region_file #(
        .NUM_REGIONS (NUM_REGIONS)
    ) u_region_file (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .words (words)
    );

    rtsg_result_logic #(
        .NUM_REGIONS (NUM_REGIONS)
    ) u_result_logic (
        .item   (s1_item_reg),
        .words  (words),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg <= req.data;
        end
        if (s1_adv)
        begin
            out_item_reg <= result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_item_reg;

    // An access leaving stage 1 must show up as a pending result
    `ASSERT_NEXT(a_adv_fills_out, clk, rst_n, s1_adv, out_valid_reg,
                 "retired access did not reach result register")
    // Writes always answer with zero
    `ASSERT_NEXT(a_write_zero, clk, rst_n, wr.en, out_item_reg.read_data == '0,
                 "region write produced nonzero read_data")
    // An empty input register never blocks the request side
    `ASSERT_IMPL(a_empty_ready, clk, rst_n, !s1_valid_reg, req.ready,
                 "input register empty but req not ready")
    // A stalled result with a full input register must back-pressure
    `ASSERT_IMPL(a_full_stall, clk, rst_n, s1_valid_reg && out_valid_reg && !rsp.ready,
                 !req.ready, "request taken while both stages are full")

endmodule

FILE: dv/tb_region_to_section_table_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_region_to_section_table_generator
// Self-checking bench for the region registers and computed section table.
// Drives region reads, region writes, table word reads and the unused kind
// over the request channel, predicts each read_data from its own copy of
// the region registers, and checks every response in order. Both channels
// idle at random. One phase holds the response side off long enough to
// back the request side up.
// ----------------------------------------------------------------------------
module tb_region_to_section_table_generator;

    import rtsg_pkg::*;

    localparam int    NUM_REGIONS  = NUM_REGIONS_DEF;
    localparam kind_t KIND_UNUSED  = kind_t'(2'd3);
    localparam int    TABLE_LAST   = (1 << ENTRY_W) - 1;
    localparam int    HOLD_CYCLES  = 300;    // long response stall
    localparam int    STALL_LIMIT  = 2000;   // watchdog: cycles with no transfer
    localparam int    DRAIN_CYCLES = 20;     // drain margin after the last response

    logic clk = 1'b0;
    logic rst_n;

    rtsg_stream_if #(.data_t(req_t)) req_ch ();
    rtsg_stream_if #(.data_t(rsp_t)) rsp_ch ();

    region_to_section_table_generator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------------
    // Our copy of the region registers, updated as each access transfers.
    logic [WORD_W-1:0] region_file [NUM_REGIONS];
    // read_data values still owed by the DUT, oldest first.
    logic [WORD_W-1:0] pending_read_data [$];

    int error_count    = 0;
    int results_seen   = 0;
    int writes_sent    = 0;
    int reg_reads_sent = 0;
    int table_reads    = 0;
    int table_hits     = 0;
    int unused_sent    = 0;

    // Idle odds in percent; changed between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The stimulus side bumps hold_requests (nonblocking); the response
    // driver notices the change at a clock edge and runs the stall itself.
    int hold_requests = 0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    // Sections a region word spans: one below the section size code base,
    // else a power of two (up to the whole table).
    function automatic int sections_spanned(logic [WORD_W-1:0] word);
        logic [SIZE_W-1:0] code;
        code = word[SIZE_LSB +: SIZE_W];
        if (code < SIZE_SECTION_BASE)
        begin
            return 1;
        end
        return 1 << (code - SIZE_SECTION_BASE);
    endfunction

    // Descriptor for one section. Later regions override earlier ones; a span
    // running past the last section simply never matches beyond it.
    function automatic logic [WORD_W-1:0] section_descriptor(logic [ENTRY_W-1:0] entry);
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] found;
        int                base;
        found = '0;
        for (int r = 0; r < NUM_REGIONS; r++)
        begin
            word = region_file[r];
            base = int'(word[START_LSB +: ENTRY_W]);
            if (int'(entry) >= base && int'(entry) - base < sections_spanned(word))
            begin
                found = {entry, 20'h0_0000} | (word & ATTR_MASK) | FIXED_BITS;
            end
        end
        return found;
    endfunction

    // Applies one access to the region copy and returns the read_data owed.
    function automatic logic [WORD_W-1:0] apply_access(req_t a);
        logic [WORD_W-1:0] owed;
        owed = '0;
        case (a.kind)
            KIND_REGION_READ:
            begin
                reg_reads_sent++;
                if (int'(a.region_number) < NUM_REGIONS)
                begin
                    owed = region_file[a.region_number];
                end
            end
            KIND_REGION_WRITE:
            begin
                writes_sent++;
                if (int'(a.region_number) < NUM_REGIONS)
                begin
                    region_file[a.region_number] = a.write_data;
                end
            end
            KIND_TABLE_READ:
            begin
                table_reads++;
                owed = section_descriptor(a.entry_index);
                if (owed != '0)
                begin
                    table_hits++;
                end
            end
            default:
            begin
                unused_sent++;
            end
        endcase
        return owed;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    function automatic req_t make_access(kind_t k, int rn, int entry, logic [WORD_W-1:0] wd);
        req_t a;
        a.kind          = k;
        a.region_number = REGION_NUM_W'(rn);
        a.entry_index   = ENTRY_W'(entry);
        a.write_data    = wd;
        return a;
    endfunction

    // Offers one access, idling first at the current odds, and records the
    // owed result at the edge where the transfer happens. valid stays high
    // on return so back-to-back calls produce back-to-back transfers.
    task automatic send_access(req_t a);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= req_t'({$urandom, $urandom});
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= a;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        pending_read_data.push_back(apply_access(a));
    endtask

    // Random access, mostly aimed at the interesting spots: region words with
    // a start at the table ends and large size codes, and table reads at or
    // just around the edges of spans that are currently programmed.
    function automatic req_t random_access();
        int                pick;
        int                rn;
        int                entry;
        int                span;
        logic [ENTRY_W-1:0] start;
        logic [WORD_W-1:0] wd;
        pick = $urandom_range(0, 99);
        rn   = $urandom_range(0, NUM_REGIONS - 1);
        wd   = $urandom;
        entry = $urandom_range(0, TABLE_LAST);
        if (pick < 30)
        begin
            case ($urandom_range(0, 7))
                0:       start = '0;
                1:       start = '1;
                2:       start = ENTRY_W'($urandom_range(TABLE_LAST - 15, TABLE_LAST));
                default: start = ENTRY_W'($urandom);
            endcase
            wd[START_LSB +: ENTRY_W] = start;
            if ($urandom_range(0, 3) == 0)
            begin
                wd[SIZE_LSB +: SIZE_W] = SIZE_W'($urandom_range(0, SIZE_ONE_SECTION_MAX));
            end
            else
            begin
                wd[SIZE_LSB +: SIZE_W] = SIZE_W'($urandom_range(SIZE_SECTION_BASE, 31));
            end
            return make_access(KIND_REGION_WRITE, rn, entry, wd);
        end
        if (pick < 52)
        begin
            return make_access(KIND_REGION_READ, rn, entry, wd);
        end
        if (pick < 95)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                span = sections_spanned(region_file[rn]);
                entry = int'(region_file[rn][START_LSB +: ENTRY_W]);
                case ($urandom_range(0, 4))
                    0:       entry = entry - 1;
                    1:       entry = entry + span - 1;
                    2:       entry = entry + span;
                    3:       entry = entry + $urandom_range(0, span - 1);
                    default: ;
                endcase
                entry = entry & TABLE_LAST;
            end
            return make_access(KIND_TABLE_READ, rn, entry, wd);
        end
        return make_access(KIND_UNUSED, rn, entry, wd);
    endfunction

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(string what, logic [WORD_W-1:0] seen,
                                 logic [WORD_W-1:0] wanted);
        error_count++;
        $display("%0t ERROR %s: read_data 0x%08h, predicted 0x%08h",
                 $realtime, what, seen, wanted);
    endtask

    // ready driver: random holes at the current odds, or a long hold-off
    // when asked for one.
    initial
    begin : rsp_ready_driver
        int hold_served;
        int hold_left;
        hold_served  = 0;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Checks every response transfer against the oldest owed value.
    always @(posedge clk)
    begin : rsp_checker
        logic [WORD_W-1:0] wanted;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_read_data.size() == 0)
            begin
                flag_mismatch("response with no access outstanding",
                              rsp_ch.data.read_data, '0);
            end
            else
            begin
                wanted = pending_read_data.pop_front();
                if (rsp_ch.data.read_data !== wanted)
                begin
                    flag_mismatch("read_data", rsp_ch.data.read_data, wanted);
                end
            end
        end
    end

    // Watchdog: gives up after too long with no transfer on either channel.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t ERROR timeout: no transfer for %0d cycles, %0d results owed",
                 $realtime, STALL_LIMIT, pending_read_data.size());
        $display("tb_region_to_section_table_generator: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Registers come out of reset zero: every region starts at section 0
    // with a one-section span, so section 0 is the only live entry.
    task automatic test_reset_state();
        send_access(make_access(KIND_REGION_READ, 0, 0, '0));
        send_access(make_access(KIND_REGION_READ, NUM_REGIONS - 1, 0, '0));
        send_access(make_access(KIND_TABLE_READ, 0, TABLE_LAST, '0));
    endtask

    // Field extremes, each kind, size code on both sides of the one-section
    // limit, overlap priority, a span clipped at the table end, unused kind.
    task automatic test_directed_regions();
        // Top region with all bits set: starts at the last section, largest
        // span, so everything past the table end is dropped.
        send_access(make_access(KIND_REGION_WRITE, 7, 0, 32'hFFFF_FFFF));
        send_access(make_access(KIND_REGION_READ, 7, 0, '0));
        send_access(make_access(KIND_TABLE_READ, 0, TABLE_LAST, '0));
        send_access(make_access(KIND_TABLE_READ, 0, TABLE_LAST - 1, '0));
        // Last one-section code, then a two-section region on top of it.
        send_access(make_access(KIND_REGION_WRITE, 0, 0, 32'h0021_2ABC));
        send_access(make_access(KIND_REGION_WRITE, 1, 0, 32'h0021_45A5));
        send_access(make_access(KIND_TABLE_READ, 0, 2, '0));
        send_access(make_access(KIND_TABLE_READ, 0, 3, '0));
        send_access(make_access(KIND_TABLE_READ, 0, 1, '0));
        // First power-of-two code: still exactly one section.
        send_access(make_access(KIND_REGION_WRITE, 4, 0, 32'h0201_3FFF));
        send_access(make_access(KIND_TABLE_READ, 0, 12'h020, '0));
        send_access(make_access(KIND_TABLE_READ, 0, 12'h021, '0));
        // Half-table region, overridden at the end by region 7.
        send_access(make_access(KIND_REGION_WRITE, 2, 0, 32'h8001_E000));
        send_access(make_access(KIND_TABLE_READ, 0, TABLE_LAST, '0));
        send_access(make_access(KIND_TABLE_READ, 0, 12'h800, '0));
        // Unused kind must not write and must answer zero.
        send_access(make_access(KIND_UNUSED, 3, TABLE_LAST, 32'hFFFF_FFFF));
        send_access(make_access(KIND_REGION_READ, 3, 0, '0));
        send_access(make_access(KIND_TABLE_READ, 0, 0, '0));
        // Clear the top region; region 2 takes the last section back.
        send_access(make_access(KIND_REGION_WRITE, 7, 0, '0));
        send_access(make_access(KIND_REGION_READ, 7, 0, '0));
        send_access(make_access(KIND_TABLE_READ, 0, TABLE_LAST, '0));
        send_access(make_access(KIND_REGION_READ, 0, 0, '0));
    endtask

    task automatic test_random_traffic(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
        begin
            send_access(random_access());
        end
    endtask

    // Response side stalls for a long stretch while requests keep coming:
    // both stages fill and req.ready must drop until the stall ends.
    task automatic test_response_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests <= hold_requests + 1;
        repeat (40)
        begin
            send_access(random_access());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : main
        for (int r = 0; r < NUM_REGIONS; r++)
        begin
            region_file[r] = '0;
        end
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 83;
        test_reset_state();
        test_directed_regions();
        test_random_traffic(300, 37, 83);
        test_response_backpressure();
        test_random_traffic(300, 83, 37);
        test_random_traffic(290, 0, 0);

        req_ch.valid <= 1'b0;
        while (pending_read_data.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d region writes, %0d region reads, %0d unused-kind accesses",
                 writes_sent, reg_reads_sent, unused_sent);
        $display("covered %0d table reads (%0d matched a region); %0d responses checked",
                 table_reads, table_hits, results_seen);
        if (error_count == 0)
        begin
            $display("tb_region_to_section_table_generator: clean");
        end
        else
        begin
            $display("tb_region_to_section_table_generator: errors");
        end
        $finish;
    end

endmodule
